### design/nksel_pkg.sv
// Package of types and constants for the nearest-K sorted ellipse list.
`timescale 1ns / 1ps
`default_nettype none

package nksel_pkg;

   // Width of a squared centre distance.
   localparam int DIST_W = 34;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_READOUT = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic REG_REF_X = 1'b0;
   localparam logic REG_REF_Y = 1'b1;

   // One input transaction.
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        box_width;
      logic [15:0]        box_height;
      logic [15:0]        box_angle;
      logic [15:0]        line_tag;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [3:0]         slot;
      logic [3:0]         count;
      logic signed [15:0] out_center_x;
      logic signed [15:0] out_center_y;
      logic [15:0]        out_width;
      logic [15:0]        out_height;
      logic [15:0]        out_angle;
      logic [15:0]        out_tag;
      logic               entry_valid;
      logic               last;
   } rsp_type;

   // One stored list entry: distance, geometry and attributes.
   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        width;
      logic [15:0]        height;
      logic [15:0]        angle;
      logic [15:0]        tag;
   } entry_type;

endpackage

`default_nettype wire

### design/nksel_list_mem.sv
// Entry store of the sorted list: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nksel_list_mem
   import nksel_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data is held until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/nearest_k_sorted_ellipse_list_unit.sv
// Top level of the nearest-K sorted ellipse list.
//
//   Port group   Direction   Handshake           Payload
//   req_         in          req_valid/req_stall  req_type
//   rsp_         out         rsp_valid/rsp_stall  rsp_type
//   csr_         in          APB write/read       ref_x, ref_y
//
// One transaction is taken at a time. An insert steps through the offset,
// square-x, square-y and start states, a farthest-entry check on a full list,
// a shift per entry that moves down and one when a held entry stays in front
// of the new one, then the place and result states; a dropped insert goes
// from the check to the result. The shared 16 by 16 multiplier squares both
// offsets in turn and one memory read/write pair per cycle moves the entries.
// A readout sends the held entries in list order, a clear or other code one
// result. After reset the list is empty and no clearing pass is needed.
// A stalled result waits in the output register; the sequencer holds until
// it is taken.
`timescale 1ns / 1ps
`default_nettype none

module nearest_k_sorted_ellipse_list_unit
   import nksel_pkg::*;
#(
   parameter int LIST_SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IDX_W = $clog2(LIST_SLOTS);
   localparam int CNT_W = $clog2(LIST_SLOTS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(LIST_SLOTS - 1);
   localparam logic [IDX_W-1:0] NEXT_IDX   = IDX_W'(LIST_SLOTS - 2);
   localparam logic [3:0]       DROP_SLOT  = 4'(LIST_SLOTS);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DIFF      = 4'd1;
   localparam logic [3:0] ST_SQX       = 4'd2;
   localparam logic [3:0] ST_SQY       = 4'd3;
   localparam logic [3:0] ST_INS_START = 4'd4;
   localparam logic [3:0] ST_FULL_CMP  = 4'd5;
   localparam logic [3:0] ST_SHIFT     = 4'd6;
   localparam logic [3:0] ST_PLACE     = 4'd7;
   localparam logic [3:0] ST_EMIT      = 4'd8;
   localparam logic [3:0] ST_RD_EMIT   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   req_type           item_ff, item_in;
   logic [15:0]       ax_ff, ax_in;
   logic [15:0]       ay_ff, ay_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              emit_valid_ff, emit_valid_in;
   logic [3:0]        slot_ff, slot_in;
   logic [15:0]       ref_x_ff, ref_y_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              csr_write;
   logic signed [16:0] dx, dy;
   logic [16:0]       dx_neg, dy_neg;
   logic [15:0]       mul_a;
   logic [31:0]       product;
   logic              closer;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   entry_type         mem_rd_data;
   entry_type         new_entry;

   // Handshakes.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Configuration port: reference point registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_REF_Y) ? {16'd0, ref_y_ff} : {16'd0, ref_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_REF_X) begin
            ref_x_ff <= csr_pwdata[15:0];
         end else begin
            ref_y_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Centre offsets and their magnitudes; no offset can reach -65536.
   assign dx     = {item_ff.center_x[15], item_ff.center_x} - {ref_x_ff[15], ref_x_ff};
   assign dy     = {item_ff.center_y[15], item_ff.center_y} - {ref_y_ff[15], ref_y_ff};
   assign dx_neg = ~dx + 17'd1;
   assign dy_neg = ~dy + 17'd1;

   // The shared multiplier squares the x offset, then the y offset.
   assign mul_a   = (state_ff == ST_SQX) ? ax_ff : ay_ff;
   assign product = 32'(mul_a) * 32'(mul_a);

   // The new entry goes in front of a held entry only when strictly nearer.
   assign closer = (dist_ff < mem_rd_data.distance);

   always_comb begin
      new_entry          = '0;
      new_entry.distance = dist_ff;
      new_entry.center_x = item_ff.center_x;
      new_entry.center_y = item_ff.center_y;
      new_entry.width    = item_ff.box_width;
      new_entry.height   = item_ff.box_height;
      new_entry.angle    = item_ff.box_angle;
      new_entry.tag      = item_ff.line_tag;
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      dist_in       = dist_ff;
      emit_valid_in = emit_valid_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = new_entry;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in       = req_data;
               emit_valid_in = 1'b0;
               slot_in       = '0;
               case (req_data.mode)
                  MODE_INSERT: begin
                     state_in = ST_DIFF;
                  end
                  MODE_READOUT: begin
                     if (count_ff == '0) begin
                        state_in = ST_EMIT;
                     end else begin
                        idx_in      = '0;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        state_in    = ST_RD_EMIT;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_DIFF: begin
            ax_in    = dx[16] ? dx_neg[15:0] : dx[15:0];
            ay_in    = dy[16] ? dy_neg[15:0] : dy[15:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            dist_in  = DIST_W'(product);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            dist_in  = dist_ff + DIST_W'(product);
            state_in = ST_INS_START;
         end
         ST_INS_START: begin
            if (count_ff == FULL_COUNT) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = LAST_IDX;
               state_in    = ST_FULL_CMP;
            end else if (count_ff == '0) begin
               idx_in   = '0;
               state_in = ST_PLACE;
            end else begin
               idx_in      = IDX_W'(count_ff);
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(count_ff - CNT_W'(1));
               state_in    = ST_SHIFT;
            end
         end
         ST_FULL_CMP: begin
            // Full list: the new entry is dropped unless nearer than the last.
            if (closer) begin
               idx_in      = LAST_IDX;
               mem_rd_en   = 1'b1;
               mem_rd_addr = NEXT_IDX;
               state_in    = ST_SHIFT;
            end else begin
               emit_valid_in = 1'b0;
               slot_in       = DROP_SLOT;
               state_in      = ST_EMIT;
            end
         end
         ST_SHIFT: begin
            // Move a farther entry down one place and look at the one above.
            if (closer) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = idx_ff;
               mem_wr_data = mem_rd_data;
               idx_in      = idx_ff - IDX_W'(1);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_ff - IDX_W'(2);
               end
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = idx_ff;
            mem_wr_data   = new_entry;
            emit_valid_in = 1'b1;
            slot_in       = 4'(idx_ff);
            if (count_ff != FULL_COUNT) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in.slot    = slot_ff;
               rsp_data_in.count   = 4'(count_ff);
               rsp_data_in.last    = 1'b1;
               if (emit_valid_ff) begin
                  rsp_data_in.out_center_x = item_ff.center_x;
                  rsp_data_in.out_center_y = item_ff.center_y;
                  rsp_data_in.out_width    = item_ff.box_width;
                  rsp_data_in.out_height   = item_ff.box_height;
                  rsp_data_in.out_angle    = item_ff.box_angle;
                  rsp_data_in.out_tag      = item_ff.line_tag;
                  rsp_data_in.entry_valid  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_RD_EMIT: begin
            // Send the entry just read and fetch the next one.
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.slot         = 4'(idx_ff);
               rsp_data_in.count        = 4'(count_ff);
               rsp_data_in.out_center_x = mem_rd_data.center_x;
               rsp_data_in.out_center_y = mem_rd_data.center_y;
               rsp_data_in.out_width    = mem_rd_data.width;
               rsp_data_in.out_height   = mem_rd_data.height;
               rsp_data_in.out_angle    = mem_rd_data.angle;
               rsp_data_in.out_tag      = mem_rd_data.tag;
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.last         = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
               if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      item_ff       <= item_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      dist_ff       <= dist_in;
      emit_valid_ff <= emit_valid_in;
      slot_ff       <= slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Entry store.
   nksel_list_mem #(
      .DEPTH  (LIST_SLOTS),
      .ADDR_W (IDX_W)
   ) u_list_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the nearest-K sorted ellipse list unit.
`timescale 1ns / 1ps

module testbench;
   import nksel_pkg::*;

   localparam int LIST_SLOTS = 8;
   // Longest insert plus margin, waited out before a register write and at the end.
   localparam int SETTLE_CYCLES = LIST_SLOTS + 12;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 86;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [2:0] ADDR_REF_X = 3'(4 * REG_REF_X);
   localparam logic [2:0] ADDR_REF_Y = 3'(4 * REG_REF_Y);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the block's configuration and sorted list.
   logic signed [15:0] ref_x_now = '0;
   logic signed [15:0] ref_y_now = '0;
   int                 shadow_count = 0;
   entry_type          shadow_list [LIST_SLOTS];

   req_type ellipses_to_send [$];
   rsp_type list_results_due [$];
   rsp_type oldest_due;

   int mismatch_count = 0;
   int gap_left = 0;
   int hold_left = 0;
   int cycle_count = 0;
   bit quiet_tail = 1'b0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;

   nearest_k_sorted_ellipse_list_unit #(
      .LIST_SLOTS(LIST_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Squared distance of a centre from the current reference point, exact.
   function automatic logic [DIST_W-1:0] squared_distance(input logic signed [15:0] cx,
                                                          input logic signed [15:0] cy);
      longint dx;
      longint dy;
      dx = longint'(cx) - longint'(ref_x_now);
      dy = longint'(cy) - longint'(ref_y_now);
      return DIST_W'(dx * dx + dy * dy);
   endfunction

   // A result that carries no entry.
   function automatic rsp_type blank_result(input logic [3:0] slot, input logic [3:0] count);
      rsp_type r;
      r = '0;
      r.slot = slot;
      r.count = count;
      r.last = 1'b1;
      return r;
   endfunction

   // A result that echoes one list entry.
   function automatic rsp_type entry_result(input logic [3:0] slot, input logic [3:0] count,
                                            input entry_type e, input logic last);
      rsp_type r;
      r.slot = slot;
      r.count = count;
      r.out_center_x = e.center_x;
      r.out_center_y = e.center_y;
      r.out_width = e.width;
      r.out_height = e.height;
      r.out_angle = e.angle;
      r.out_tag = e.tag;
      r.entry_valid = 1'b1;
      r.last = last;
      return r;
   endfunction

   // Applies one accepted transaction to the shadow list and queues the results it causes.
   task automatic advance_shadow_list(input req_type item);
      entry_type fresh;
      int pos;
      int k;
      case (item.mode)
         MODE_INSERT: begin
            fresh.distance = squared_distance(item.center_x, item.center_y);
            fresh.center_x = item.center_x;
            fresh.center_y = item.center_y;
            fresh.width = item.box_width;
            fresh.height = item.box_height;
            fresh.angle = item.box_angle;
            fresh.tag = item.line_tag;
            // The new entry goes after every held entry that is no farther.
            pos = 0;
            while (pos < shadow_count && !(fresh.distance < shadow_list[pos].distance))
               pos++;
            if (pos >= LIST_SLOTS) begin
               list_results_due.push_back(blank_result(4'(LIST_SLOTS), 4'(shadow_count)));
            end else begin
               for (k = (shadow_count < LIST_SLOTS) ? shadow_count : LIST_SLOTS - 1;
                    k > pos; k--)
                  shadow_list[k] = shadow_list[k - 1];
               shadow_list[pos] = fresh;
               if (shadow_count < LIST_SLOTS)
                  shadow_count++;
               list_results_due.push_back(entry_result(4'(pos), 4'(shadow_count), fresh, 1'b1));
            end
         end
         MODE_READOUT: begin
            if (shadow_count == 0)
               list_results_due.push_back(blank_result(4'd0, 4'd0));
            for (k = 0; k < shadow_count; k++)
               list_results_due.push_back(entry_result(4'(k), 4'(shadow_count), shadow_list[k],
                                                       k + 1 == shadow_count));
         end
         MODE_CLEAR: begin
            shadow_count = 0;
            list_results_due.push_back(blank_result(4'd0, 4'd0));
         end
         default: begin
            list_results_due.push_back(blank_result(4'd0, 4'(shadow_count)));
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Request driver: offers queued ellipses, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            advance_shadow_list(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (ellipses_to_send.size() != 0 && !quiet_tail &&
                         $urandom_range(0, 11) == 0) begin
               // This cycle is the first of the burst.
               gap_left <= $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else if (ellipses_to_send.size() != 0) begin
               req_data <= ellipses_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transaction and drives the stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (list_results_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               oldest_due = list_results_due.pop_front();
               check_field("slot", 16'(oldest_due.slot), 16'(rsp_data.slot));
               check_field("count", 16'(oldest_due.count), 16'(rsp_data.count));
               check_field("out_center_x", oldest_due.out_center_x, rsp_data.out_center_x);
               check_field("out_center_y", oldest_due.out_center_y, rsp_data.out_center_y);
               check_field("out_width", oldest_due.out_width, rsp_data.out_width);
               check_field("out_height", oldest_due.out_height, rsp_data.out_height);
               check_field("out_angle", oldest_due.out_angle, rsp_data.out_angle);
               check_field("out_tag", oldest_due.out_tag, rsp_data.out_tag);
               check_field("entry_valid", 16'(oldest_due.entry_valid), 16'(rsp_data.entry_valid));
               check_field("last", 16'(oldest_due.last), 16'(rsp_data.last));
            end
         end
         // One long hold-off fills the block; otherwise short random bursts.
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [1:0] mode, input int cx, input int cy,
                                         input int w, input int h, input int a, input int tag);
      req_type item;
      item.mode = mode;
      item.center_x = 16'(cx);
      item.center_y = 16'(cy);
      item.box_width = 16'(w);
      item.box_height = 16'(h);
      item.box_angle = 16'(a);
      item.line_tag = 16'(tag);
      return item;
   endfunction

   // Coordinates spread over the full range, near the reference, or tightly clustered for ties.
   function automatic logic signed [15:0] pick_coord(input logic signed [15:0] centre);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'(int'(centre) + int'($urandom_range(0, 64)) - 32);
         default: return 16'(int'(centre) + int'($urandom_range(0, 4)) - 2);
      endcase
   endfunction

   // Mostly inserts, with readouts, clears and the unused code mixed in.
   function automatic req_type random_item();
      req_type item;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         item.mode = MODE_INSERT;
      else if (pick < 86)
         item.mode = MODE_READOUT;
      else if (pick < 94)
         item.mode = MODE_CLEAR;
      else
         item.mode = MODE_UNUSED;
      item.center_x = pick_coord(ref_x_now);
      item.center_y = pick_coord(ref_y_now);
      item.box_width = 16'($urandom);
      item.box_height = 16'($urandom);
      item.box_angle = 16'($urandom);
      item.line_tag = 16'($urandom);
      return item;
   endfunction

   // Waits until every ellipse is sent and every result has arrived, then lets the block settle.
   task automatic wait_idle();
      @(posedge clock);
      #1;
      while (ellipses_to_send.size() != 0 || req_valid || list_results_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      #1;
   endtask

   // One register write followed by a read-back of the same register.
   task automatic csr_write_checked(input logic [2:0] addr, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // The register takes the value at this edge.
      if (addr == ADDR_REF_X)
         ref_x_now = 16'(value);
      else
         ref_y_now = 16'(value);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register read-back", 16'(value), csr_prdata[15:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stimulus sequence: directed items, then random phases under several reference points.
   initial begin
      int phase;
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty list, unused code and clear on an empty list.
      ellipses_to_send.push_back(make_item(MODE_READOUT, 0, 0, 0, 0, 0, 0));
      ellipses_to_send.push_back(make_item(MODE_UNUSED, -1, -1, 65535, 65535, 65535, 65535));
      ellipses_to_send.push_back(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
      // Field extremes, then equal distances that must land behind the held ones.
      ellipses_to_send.push_back(make_item(MODE_INSERT, 32767, -32768, 65535, 0, 65535, 0));
      ellipses_to_send.push_back(make_item(MODE_INSERT, -32768, -32768, 0, 65535, 0, 65535));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 0, 0, 1, 2, 3, 4));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 0, 0, 5, 6, 7, 8));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 16, 0, 9, 10, 11, 12));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 0, -16, 13, 14, 15, 16));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 3, 4, 17, 18, 19, 20));
      ellipses_to_send.push_back(make_item(MODE_INSERT, -5, 0, 21, 22, 23, 24));
      // Full list: an equally far entry is dropped, a nearer one pushes the farthest out.
      ellipses_to_send.push_back(make_item(MODE_INSERT, -32768, -32768, 25, 26, 27, 28));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 32767, 32767, 29, 30, 31, 32));
      ellipses_to_send.push_back(make_item(MODE_INSERT, -32768, 32767, 33, 34, 35, 36));
      ellipses_to_send.push_back(make_item(MODE_READOUT, 0, 0, 0, 0, 0, 0));
      ellipses_to_send.push_back(make_item(MODE_UNUSED, 0, 0, 0, 0, 0, 0));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 1, 1, 37, 38, 39, 40));
      ellipses_to_send.push_back(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
      ellipses_to_send.push_back(make_item(MODE_READOUT, 0, 0, 0, 0, 0, 0));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 100, -100, 41, 42, 43, 44));
      ellipses_to_send.push_back(make_item(MODE_READOUT, 0, 0, 0, 0, 0, 0));

      // A new reference leaves the stored distance of the held entry as it was.
      wait_idle();
      csr_write_checked(ADDR_REF_X, 32767);
      csr_write_checked(ADDR_REF_Y, 32767);
      ellipses_to_send.push_back(make_item(MODE_INSERT, -32768, -32768, 45, 46, 47, 48));
      ellipses_to_send.push_back(make_item(MODE_INSERT, 32767, 32767, 49, 50, 51, 52));
      ellipses_to_send.push_back(make_item(MODE_READOUT, 0, 0, 0, 0, 0, 0));

      // Random phases; the sender pauses for the block to drain before each register change.
      for (phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               csr_write_checked(ADDR_REF_X, -32768);
               csr_write_checked(ADDR_REF_Y, -32768);
            end
            2: begin
               csr_write_checked(ADDR_REF_X, 32767);
               csr_write_checked(ADDR_REF_Y, -32768);
            end
            default: begin
               csr_write_checked(ADDR_REF_X, int'($urandom_range(0, 65535)) - 32768);
               csr_write_checked(ADDR_REF_Y, int'($urandom_range(0, 65535)) - 32768);
            end
         endcase
         if (phase == 3)
            quiet_tail = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            ellipses_to_send.push_back(random_item());
         if (phase == 0)
            long_hold_req = 1'b1;
      end

      wait_idle();
      if (mismatch_count == 0 && list_results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### sim.f
design/nksel_pkg.sv
design/nksel_list_mem.sv
design/nearest_k_sorted_ellipse_list_unit.sv
tb/testbench.sv
